FILE: src/emcd_pkg.sv
package emcd_pkg;

   // Pipeline depth from accepted item to result strobe
   localparam int unsigned PIPE_DEPTH = 15;

   // Milliseconds per day over 1024, and its truncated reciprocal (Q40)
   localparam logic [16:0] DAY_DIV = 17'd84375;
   localparam logic [23:0] DAY_RCP = 24'((64'd1 << 40) / 64'd84375);

   // Rounded-up reciprocals; each shift covers the dividend width plus divisor bits
   localparam logic [24:0] RCP_125     = 25'(((64'd1 << 31) + 64'd124) / 64'd125);
   localparam logic [15:0] RCP_15_SOD  = 16'(((64'd1 << 19) + 64'd14) / 64'd15);
   localparam logic [9:0]  RCP_15_MOD  = 10'(((64'd1 << 13) + 64'd14) / 64'd15);
   localparam logic [22:0] RCP_ERA     = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
   localparam logic [22:0] RCP_7       = 23'(((64'd1 << 25) + 64'd6) / 64'd7);
   localparam logic [16:0] RCP_365_DOE = 17'(((64'd1 << 25) + 64'd364) / 64'd365);
   localparam logic [16:0] RCP_9131    = 17'(((64'd1 << 30) + 64'd9130) / 64'd9131);
   localparam logic [18:0] RCP_365_YR  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
   localparam logic [7:0]  RCP_25      = 8'(((64'd1 << 12) + 64'd24) / 64'd25);
   localparam logic [11:0] RCP_153     = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

   // Day count of 1970-01-01 relative to 0000-03-01, and era length
   localparam logic [21:0] EPOCH_SHIFT  = 22'd719468;
   localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
   localparam logic [17:0] LAST_DOE     = 18'd146096;
   localparam logic [21:0] WDAY_SHIFT   = 22'd4;

   // Time-of-day fields and weekday, carried alongside the date stages
   typedef struct packed {
      logic [9:0] msec;
      logic [5:0] sec;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [2:0] wday;
   } clock_fields_type;

   // First day of each month within a March-based year
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] ofs;
      case (mp)
         4'd0:    ofs = 9'd0;
         4'd1:    ofs = 9'd31;
         4'd2:    ofs = 9'd61;
         4'd3:    ofs = 9'd92;
         4'd4:    ofs = 9'd122;
         4'd5:    ofs = 9'd153;
         4'd6:    ofs = 9'd184;
         4'd7:    ofs = 9'd214;
         4'd8:    ofs = 9'd245;
         4'd9:    ofs = 9'd275;
         4'd10:   ofs = 9'd306;
         4'd11:   ofs = 9'd337;
         default: ofs = 9'd0;
      endcase
      return ofs;
   endfunction

endpackage

FILE: src/epoch_ms_to_civil_date_top.sv
// Epoch millisecond count to broken-down UTC calendar time.
//
// Input: drive req_epoch_millis and raise start; the item is taken at a
// rising edge where start is high and busy is low. Results: one item per
// input, shown on the rsp_ ports for exactly one cycle with rsp_valid high.
// The receiver cannot hold results off, and none is needed.
//
// Throughput is one item per cycle while busy is low: every stage is a
// register slice of a fixed pipeline built around constant-reciprocal
// multipliers (day split, time-of-day split, era split, year-of-era,
// month).
//
// Reset clears every valid bit, so items in flight are dropped and no
// result appears. busy is high during reset and for the cycle after it,
// and low otherwise.
module epoch_ms_to_civil_date_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [47:0] req_epoch_millis,
   output logic        rsp_valid,
   output logic [9:0]  rsp_millisecond,
   output logic [5:0]  rsp_second,
   output logic [5:0]  rsp_minute,
   output logic [4:0]  rsp_hour,
   output logic [2:0]  rsp_weekday,
   output logic [4:0]  rsp_day_of_month,
   output logic [3:0]  rsp_month,
   output logic [13:0] rsp_year
);

   localparam int unsigned CLK_DLY = 6;

   logic                             busy_ff;
   logic [emcd_pkg::PIPE_DEPTH-1:0]  vld_ff;
   logic                             accept;

   // Day split
   logic [47:0] x_ff;
   logic [45:0] day_prod;
   logic [21:0] qe_in, qe_ff, qe3_ff;
   logic [27:0] xl2_ff, xl3_ff;
   logic [17:0] prd_in, prd_ff;
   logic [17:0] r0, r1, r2;
   logic        c1, c2;
   logic [21:0] days_in, days_ff;
   logic [26:0] tod_in, tod_ff;

   // Time of day
   logic [48:0] sod_prod;
   logic [16:0] sod_in, sod5_ff;
   logic [9:0]  msl5_ff, ms_in, ms6_ff, ms7_ff;
   logic [30:0] mod_prod;
   logic [10:0] mod_in, mod6_ff;
   logic [5:0]  sod6_ff, sec_in, sec7_ff, mod7_ff;
   logic [18:0] hr_prod;
   logic [4:0]  hr_in, hr7_ff;
   emcd_pkg::clock_fields_type clk_in, clk8_ff;
   emcd_pkg::clock_fields_type clk_dly_ff [0:CLK_DLY-1];

   // Date
   logic [21:0] z5_ff, wv5_ff, z6_ff;
   logic [44:0] era_prod, wd_prod;
   logic [4:0]  era_in, era6_ff, era7_ff, era8_ff, era9_ff, era10_ff;
   logic [18:0] q7_in, q7_6_ff;
   logic [2:0]  wv6_ff, wd_in, wd7_ff;
   logic [17:0] doe_in, doe7_ff, doe8_ff, doe9_ff, doe10_ff, doe11_ff;
   logic [32:0] a_prod, b_prod;
   logic [6:0]  a_in, a8_ff;
   logic [2:0]  b_in, b8_ff;
   logic        c_in, c8_ff;
   logic [17:0] n_in, n9_ff;
   logic [36:0] yoe_prod;
   logic [8:0]  yoe_in, yoe10_ff;
   logic [14:0] cent_prod;
   logic [1:0]  cent;
   logic [17:0] yrd_in, yrd11_ff;
   logic [13:0] yr_in, yr11_ff, yr12_ff, yr13_ff, yr14_ff;
   logic [8:0]  doy_in, doy12_ff, doy13_ff, doy14_ff;
   logic [10:0] v_in, v13_ff;
   logic [22:0] mp_prod;
   logic [3:0]  mp_in, mp14_ff;

   // Output stage
   logic [4:0]  dom_in;
   logic [3:0]  mon_in;
   logic [13:0] year_in;
   logic [9:0]  out_ms_ff;
   logic [5:0]  out_sec_ff, out_min_ff;
   logic [4:0]  out_hr_ff, out_dom_ff;
   logic [2:0]  out_wd_ff;
   logic [3:0]  out_mon_ff;
   logic [13:0] out_year_ff;

   assign accept = start && !busy_ff;

   // Estimate whole days from the top bits of the count over 1024
   always_comb begin
      day_prod = 46'(x_ff[47:26]) * 46'(emcd_pkg::DAY_RCP);
      qe_in    = day_prod[45:24];
      prd_in   = 18'(qe_ff * 22'(emcd_pkg::DAY_DIV));
   end

   // Correct the estimate: it falls short by at most two days
   always_comb begin
      r0 = xl3_ff[27:10] - prd_ff;
      c1 = (r0 >= {1'b0, emcd_pkg::DAY_DIV});
      r1 = c1 ? r0 - {1'b0, emcd_pkg::DAY_DIV} : r0;
      c2 = (r1 >= {1'b0, emcd_pkg::DAY_DIV});
      r2 = c2 ? r1 - {1'b0, emcd_pkg::DAY_DIV} : r1;
      days_in = qe3_ff + 22'(c1) + 22'(c2);
      tod_in  = {r2[16:0], xl3_ff[9:0]};
   end

   // Split time of day into milliseconds, seconds, minutes and hours, packed with the weekday
   always_comb begin
      sod_prod = 49'(tod_ff[26:3]) * 49'(emcd_pkg::RCP_125);
      sod_in   = sod_prod[47:31];
      ms_in    = msl5_ff - 10'(sod5_ff * 17'd1000);
      mod_prod = 31'(sod5_ff[16:2]) * 31'(emcd_pkg::RCP_15_SOD);
      mod_in   = mod_prod[29:19];
      sec_in   = sod6_ff - 6'(mod6_ff * 11'd60);
      hr_prod  = 19'(mod6_ff[10:2]) * 19'(emcd_pkg::RCP_15_MOD);
      hr_in    = hr_prod[17:13];
      clk_in.msec   = ms7_ff;
      clk_in.sec    = sec7_ff;
      clk_in.minute = mod7_ff - (6'(hr7_ff) * 6'd60);
      clk_in.hour   = hr7_ff;
      clk_in.wday   = wd7_ff;
   end

   // Split days into era, day of era and weekday
   always_comb begin
      era_prod = 45'(z5_ff) * 45'(emcd_pkg::RCP_ERA);
      era_in   = era_prod[44:40];
      wd_prod  = 45'(wv5_ff) * 45'(emcd_pkg::RCP_7);
      q7_in    = wd_prod[43:25];
      doe_in   = 18'(z6_ff - (22'(era6_ff) * 22'(emcd_pkg::DAYS_PER_ERA)));
      wd_in    = wv6_ff - 3'(q7_6_ff * 19'd7);
   end

   // Year of era, day of year and month
   always_comb begin
      a_prod    = 33'(doe7_ff[17:2]) * 33'(emcd_pkg::RCP_365_DOE);
      a_in      = a_prod[31:25];
      b_prod    = 33'(doe7_ff[17:2]) * 33'(emcd_pkg::RCP_9131);
      b_in      = b_prod[32:30];
      c_in      = (doe7_ff == emcd_pkg::LAST_DOE);
      n_in      = doe8_ff - 18'(a8_ff) + 18'(b8_ff) - 18'(c8_ff);
      yoe_prod  = 37'(n9_ff) * 37'(emcd_pkg::RCP_365_YR);
      yoe_in    = yoe_prod[35:27];
      cent_prod = 15'(yoe10_ff[8:2]) * 15'(emcd_pkg::RCP_25);
      cent      = cent_prod[13:12];
      yrd_in    = (18'(yoe10_ff) * 18'd365) + 18'(yoe10_ff[8:2]) - 18'(cent);
      yr_in     = (14'(era10_ff) * 14'd400) + 14'(yoe10_ff);
      doy_in    = 9'(doe11_ff - yrd11_ff);
      v_in      = (11'(doy12_ff) * 11'd5) + 11'd2;
      mp_prod   = 23'(v13_ff) * 23'(emcd_pkg::RCP_153);
      mp_in     = mp_prod[22:19];
   end

   // Final date fields; January and February belong to the next year
   always_comb begin
      dom_in  = 5'(doy14_ff - emcd_pkg::month_start(mp14_ff) + 9'd1);
      mon_in  = (mp14_ff < 4'd10) ? mp14_ff + 4'd3 : mp14_ff - 4'd9;
      year_in = yr14_ff + 14'(mon_in <= 4'd2);
   end

   // Advance valid bits; hold busy through reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         vld_ff  <= '0;
      end else begin
         busy_ff <= 1'b0;
         vld_ff  <= {vld_ff[emcd_pkg::PIPE_DEPTH-2:0], accept};
      end
   end

   // Advance payload every cycle
   always_ff @(posedge clock) begin
      x_ff     <= req_epoch_millis;
      qe_ff    <= qe_in;
      xl2_ff   <= x_ff[27:0];
      prd_ff   <= prd_in;
      qe3_ff   <= qe_ff;
      xl3_ff   <= xl2_ff;
      days_ff  <= days_in;
      tod_ff   <= tod_in;

      sod5_ff  <= sod_in;
      msl5_ff  <= tod_ff[9:0];
      z5_ff    <= days_ff + emcd_pkg::EPOCH_SHIFT;
      wv5_ff   <= days_ff + emcd_pkg::WDAY_SHIFT;

      ms6_ff   <= ms_in;
      sod6_ff  <= sod5_ff[5:0];
      mod6_ff  <= mod_in;
      era6_ff  <= era_in;
      z6_ff    <= z5_ff;
      q7_6_ff  <= q7_in;
      wv6_ff   <= wv5_ff[2:0];

      ms7_ff   <= ms6_ff;
      sec7_ff  <= sec_in;
      mod7_ff  <= mod6_ff[5:0];
      hr7_ff   <= hr_in;
      doe7_ff  <= doe_in;
      era7_ff  <= era6_ff;
      wd7_ff   <= wd_in;

      clk8_ff  <= clk_in;
      a8_ff    <= a_in;
      b8_ff    <= b_in;
      c8_ff    <= c_in;
      doe8_ff  <= doe7_ff;
      era8_ff  <= era7_ff;

      n9_ff    <= n_in;
      doe9_ff  <= doe8_ff;
      era9_ff  <= era8_ff;

      yoe10_ff <= yoe_in;
      doe10_ff <= doe9_ff;
      era10_ff <= era9_ff;

      yrd11_ff <= yrd_in;
      yr11_ff  <= yr_in;
      doe11_ff <= doe10_ff;

      doy12_ff <= doy_in;
      yr12_ff  <= yr11_ff;

      v13_ff   <= v_in;
      doy13_ff <= doy12_ff;
      yr13_ff  <= yr12_ff;

      mp14_ff  <= mp_in;
      doy14_ff <= doy13_ff;
      yr14_ff  <= yr13_ff;

      clk_dly_ff[0] <= clk8_ff;
      for (int i = 1; i < CLK_DLY; i++) begin
         clk_dly_ff[i] <= clk_dly_ff[i-1];
      end

      out_ms_ff   <= clk_dly_ff[CLK_DLY-1].msec;
      out_sec_ff  <= clk_dly_ff[CLK_DLY-1].sec;
      out_min_ff  <= clk_dly_ff[CLK_DLY-1].minute;
      out_hr_ff   <= clk_dly_ff[CLK_DLY-1].hour;
      out_wd_ff   <= clk_dly_ff[CLK_DLY-1].wday;
      out_dom_ff  <= dom_in;
      out_mon_ff  <= mon_in;
      out_year_ff <= year_in;
   end

   // Drive ports from the output stage
   assign busy             = busy_ff;
   assign rsp_valid        = vld_ff[emcd_pkg::PIPE_DEPTH-1];
   assign rsp_millisecond  = out_ms_ff;
   assign rsp_second       = out_sec_ff;
   assign rsp_minute       = out_min_ff;
   assign rsp_hour         = out_hr_ff;
   assign rsp_weekday      = out_wd_ff;
   assign rsp_day_of_month = out_dom_ff;
   assign rsp_month        = out_mon_ff;
   assign rsp_year         = out_year_ff;

`ifndef SYNTHESIS
   // Every accepted item comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##15 rsp_valid)
      else $error("accepted item did not produce a result on time");

   // Corrected day remainder stays within one day
   a_tod_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (tod_ff < 27'd86400000))
      else $error("time of day out of range after day correction");

   // Clock fields stay in range
   a_clock_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_millisecond < 10'd1000 && rsp_second < 6'd60 &&
                     rsp_minute < 6'd60 && rsp_hour < 5'd24 && rsp_weekday < 3'd7))
      else $error("time field out of range");

   // Date fields stay in range
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month >= 4'd1 && rsp_month <= 4'd12 &&
                     rsp_day_of_month >= 5'd1 && rsp_year >= 14'd1970))
      else $error("date field out of range");
`endif

endmodule

FILE: tb/sv/tb.sv
module tb;

   localparam longint unsigned MS_PER_SEC   = 1000;
   localparam longint unsigned SEC_PER_DAY  = 24 * 60 * 60;
   localparam longint unsigned MS_PER_DAY   = MS_PER_SEC * SEC_PER_DAY;
   localparam longint unsigned CIVIL_SHIFT  = 719468;
   localparam longint unsigned ERA_DAYS     = 146097;
   localparam longint unsigned LAST_DAY_IDX = 3257811;
   localparam int              RANDOM_ITEMS = 1250;

   // Broken-down calendar time, one field per result port
   typedef struct {
      logic [9:0]  msec;
      logic [5:0]  sec;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [2:0]  wday;
      logic [4:0]  mday;
      logic [3:0]  month;
      logic [13:0] year;
   } civil_time_type;

   // Split a millisecond stamp into time of day, weekday and a civil date, using a March-based year
   function automatic civil_time_type civil_time_of(input logic [47:0] stamp);
      longint unsigned total_sec, sec_of_day, day_count, shifted, era_idx;
      longint unsigned day_of_era, year_of_era, day_of_year, month_pos, month_num;
      civil_time_type t;
      total_sec  = longint'(stamp) / MS_PER_SEC;
      sec_of_day = total_sec % SEC_PER_DAY;
      day_count  = total_sec / SEC_PER_DAY;
      t.msec     = 10'(longint'(stamp) % MS_PER_SEC);
      t.sec      = 6'(sec_of_day % 60);
      t.minute   = 6'((sec_of_day / 60) % 60);
      t.hour     = 5'(sec_of_day / 3600);
      // 1970-01-01 was a Thursday
      t.wday     = 3'((day_count + 4) % 7);
      shifted     = day_count + CIVIL_SHIFT;
      era_idx     = shifted / ERA_DAYS;
      day_of_era  = shifted % ERA_DAYS;
      year_of_era = (day_of_era - day_of_era / 1460 + day_of_era / 36524
                     - day_of_era / 146096) / 365;
      day_of_year = day_of_era - (365 * year_of_era + year_of_era / 4 - year_of_era / 100);
      month_pos   = (5 * day_of_year + 2) / 153;
      month_num   = (month_pos < 10) ? month_pos + 3 : month_pos - 9;
      t.mday      = 5'(day_of_year - (153 * month_pos + 2) / 5 + 1);
      t.month     = 4'(month_num);
      t.year      = 14'(year_of_era + era_idx * 400 + ((month_num <= 2) ? 1 : 0));
      return t;
   endfunction

   // Hold the expected dates in order of acceptance and compare results
   class civil_date_board;
      civil_time_type due_dates[$];
      int             mismatch_count;
      int             checked_count;
      int             noted_count;

      function new();
         mismatch_count = 0;
         checked_count  = 0;
         noted_count    = 0;
      endfunction

      function void note_stamp(input logic [47:0] stamp);
         due_dates.push_back(civil_time_of(stamp));
         noted_count++;
      endfunction

      task report_mismatch(input string what);
         $display("[%0t] mismatch: %s", $time, what);
         mismatch_count++;
      endtask

      task compare_field(input string name, input int got, input int want);
         if (got != want) begin
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
         end
      endtask

      task check_date(input civil_time_type got);
         civil_time_type want;
         if (due_dates.size() == 0) begin
            report_mismatch("result with no item pending");
         end else begin
            want = due_dates.pop_front();
            checked_count++;
            compare_field("millisecond", got.msec, want.msec);
            compare_field("second", got.sec, want.sec);
            compare_field("minute", got.minute, want.minute);
            compare_field("hour", got.hour, want.hour);
            compare_field("weekday", got.wday, want.wday);
            compare_field("day_of_month", got.mday, want.mday);
            compare_field("month", got.month, want.month);
            compare_field("year", got.year, want.year);
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [47:0] req_epoch_millis;
   logic        rsp_valid;
   logic [9:0]  rsp_millisecond;
   logic [5:0]  rsp_second;
   logic [5:0]  rsp_minute;
   logic [4:0]  rsp_hour;
   logic [2:0]  rsp_weekday;
   logic [4:0]  rsp_day_of_month;
   logic [3:0]  rsp_month;
   logic [13:0] rsp_year;

   civil_date_board board = new();

   epoch_ms_to_civil_date_top uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_epoch_millis (req_epoch_millis),
      .rsp_valid        (rsp_valid),
      .rsp_millisecond  (rsp_millisecond),
      .rsp_second       (rsp_second),
      .rsp_minute       (rsp_minute),
      .rsp_hour         (rsp_hour),
      .rsp_weekday      (rsp_weekday),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_month        (rsp_month),
      .rsp_year         (rsp_year)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Check results, then note the item taken at this edge
   always @(posedge clock) begin
      civil_time_type got;
      if (rsp_valid) begin
         got.msec   = rsp_millisecond;
         got.sec    = rsp_second;
         got.minute = rsp_minute;
         got.hour   = rsp_hour;
         got.wday   = rsp_weekday;
         got.mday   = rsp_day_of_month;
         got.month  = rsp_month;
         got.year   = rsp_year;
         board.check_date(got);
      end
      if (!reset && start && !busy) begin
         board.note_stamp(req_epoch_millis);
      end
   end

   // Present one item from a falling edge and hold it until taken
   task automatic send_stamp(input logic [47:0] stamp);
      start            <= 1'b1;
      req_epoch_millis <= stamp;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Drop start for a number of cycles
   task automatic idle_cycles(input int count);
      start <= 1'b0;
      repeat (count) @(negedge clock);
   endtask

   // Mix of full-range stamps, near-term dates, day edges and era edges
   function automatic logic [47:0] pick_stamp();
      longint unsigned raw, day_idx, offset;
      int unsigned     pick;
      pick = $urandom_range(0, 9);
      raw  = {$urandom, $urandom};
      if (pick < 4) begin
         return raw[47:0];
      end else if (pick < 6) begin
         // up to around the year 2100
         return 48'(raw % 64'd4200000000000);
      end else if (pick < 9) begin
         day_idx = $urandom_range(0, int'(LAST_DAY_IDX));
         if ($urandom_range(0, 2) == 0) offset = 0;
         else if ($urandom_range(0, 1) == 0) offset = MS_PER_DAY - 1;
         else offset = raw % MS_PER_DAY;
         return 48'(day_idx * MS_PER_DAY + offset);
      end else begin
         // first day of an era, or the last millisecond before it
         day_idx = longint'($urandom_range(5, 27)) * ERA_DAYS - CIVIL_SHIFT;
         return 48'(day_idx * MS_PER_DAY - (($urandom_range(0, 1) == 0) ? 0 : 1));
      end
   endfunction

   initial begin
      logic [47:0] corner_stamps[$];
      int          sent;
      int          burst;
      reset            = 1'b1;
      start            = 1'b0;
      req_epoch_millis = '0;
      corner_stamps = '{
         48'd0, 48'hFFFF_FFFF_FFFF, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555,
         48'd999, 48'd1000, 48'd59999, 48'd3599999, 48'd86399999, 48'd86400000,
         48'd31535999999, 48'd31536000000, 48'd68169600000, 48'd68256000000,
         48'd946684799999, 48'd946684800000, 48'd951782400000, 48'd951868799999,
         48'd951868800000, 48'd4107542399999, 48'd4107542400000,
         48'd13574649599999, 48'd13574649600000, 48'd281474956799999
      };
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed corners back to back
      foreach (corner_stamps[i]) send_stamp(corner_stamps[i]);
      idle_cycles($urandom_range(1, 5));

      // Random bursts with random gaps, some of them gapless
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            send_stamp(pick_stamp());
            sent++;
         end
         if (sent >= RANDOM_ITEMS / 2 && sent - burst < RANDOM_ITEMS / 2) begin
            // hold off until the pipeline has drained
            start <= 1'b0;
            while (board.due_dates.size() != 0) @(negedge clock);
         end else if ($urandom_range(0, 3) != 0) begin
            idle_cycles($urandom_range(1, 8));
         end
      end
      start <= 1'b0;

      // Drain, then watch for strays
      while (board.due_dates.size() != 0) @(negedge clock);
      repeat (emcd_pkg::PIPE_DEPTH + 4) @(negedge clock);
      if (board.due_dates.size() != 0) begin
         board.report_mismatch("expected results left over");
      end
      $display("Converted %0d stamps (%0d corner cases), %0d results checked, %0d mismatches.",
               board.noted_count, corner_stamps.size(), board.checked_count,
               board.mismatch_count);
      $display("Covered day, year, leap-day and era edges plus full 48-bit range.");
      if (board.mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #400000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
